// ----- src/lpti_pkg.sv -----
// Shared constants, register indexes and inter-stage structs of the line projection interpolator.
package lpti_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_INTERP = 1'b1;

   typedef enum logic [2:0] {
      CSR_AXIS_START_X,
      CSR_AXIS_START_Y,
      CSR_AXIS_START_Z,
      CSR_DIRECTION_X,
      CSR_DIRECTION_Y,
      CSR_DIRECTION_Z,
      CSR_INVERSE_SPACING,
      CSR_POINT_COUNT
   } csr_index_type;

   typedef struct packed {
      logic [31:0]       start_x;
      logic [31:0]       start_y;
      logic [31:0]       start_z;
      logic [17:0]       dir_x;
      logic [17:0]       dir_y;
      logic [17:0]       dir_z;
      logic [31:0]       inv_spacing;
      logic [ADDR_W-1:0] last;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [9:0]  wr_index;
      logic [31:0] wr_value;
   } meta_type;

   typedef struct packed {
      logic        valid;
      meta_type    meta;
      logic        neg;
      logic [36:0] d16;
   } proj_type;

   typedef struct packed {
      logic              valid;
      meta_type          meta;
      logic [ADDR_W-1:0] rd_addr0;
      logic [ADDR_W-1:0] rd_addr1;
      logic              clamped;
      logic [15:0]       frac;
   } loc_type;

   typedef struct packed {
      logic        valid;
      logic        clamped;
      logic [15:0] frac;
      logic [31:0] s0;
      logic [31:0] s1;
   } samp_type;

endpackage

// ----- src/lpti_project.sv -----
// Projection stages: point offset, products with the direction, dot product sum.
module lpti_project (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               opcode,
   input  logic [31:0]        pos_x,
   input  logic [31:0]        pos_y,
   input  logic [31:0]        pos_z,
   input  logic [9:0]         wr_index,
   input  logic [31:0]        wr_value,
   input  lpti_pkg::cfg_type  cfg,
   output lpti_pkg::proj_type proj
);

   logic                 a_valid_ff, b_valid_ff, c_valid_ff;
   lpti_pkg::meta_type   a_meta_ff, b_meta_ff, c_meta_ff;
   logic signed [32:0]   dx_in, dy_in, dz_in, dx_ff, dy_ff, dz_ff;
   logic signed [50:0]   px_in, py_in, pz_in, px_ff, py_ff, pz_ff;
   logic signed [52:0]   sum_in, sum_ff;

   always_comb begin
      dx_in = $signed({pos_x[31], pos_x}) - $signed({cfg.start_x[31], cfg.start_x});
      dy_in = $signed({pos_y[31], pos_y}) - $signed({cfg.start_y[31], cfg.start_y});
      dz_in = $signed({pos_z[31], pos_z}) - $signed({cfg.start_z[31], cfg.start_z});
      px_in = dx_ff * $signed(cfg.dir_x);
      py_in = dy_ff * $signed(cfg.dir_y);
      pz_in = dz_ff * $signed(cfg.dir_z);
      sum_in = 53'(px_ff) + 53'(py_ff) + 53'(pz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_meta_ff <= '{opcode: opcode, wr_index: wr_index, wr_value: wr_value};
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      b_meta_ff <= a_meta_ff;
      px_ff     <= px_in;
      py_ff     <= py_in;
      pz_ff     <= pz_in;
      c_meta_ff <= b_meta_ff;
      sum_ff    <= sum_in;
   end

   always_comb begin
      proj.valid = c_valid_ff;
      proj.meta  = c_meta_ff;
      proj.neg   = sum_ff[52];
      // distance floored to Q.16
      proj.d16   = sum_ff[52:16];
   end

endmodule

// ----- src/lpti_locate.sv -----
// Scaling by the reciprocal spacing, bin and fraction, clamping and table addresses.
module lpti_locate (
   input  logic               clock,
   input  logic               reset,
   input  lpti_pkg::proj_type proj,
   input  lpti_pkg::cfg_type  cfg,
   output lpti_pkg::loc_type  loc
);

   logic                          d_valid_ff, e_valid_ff;
   lpti_pkg::meta_type            d_meta_ff, e_meta_ff;
   logic                          d_neg_ff;
   logic [63:0]                   plo_in, plo_ff;
   logic [36:0]                   phi_in, phi_ff;
   logic [37:0]                   bin;
   logic [37:0]                   last_ext;
   logic [31:0]                   frac;
   logic [lpti_pkg::ADDR_W-1:0]   addr0_in, addr1_in, addr0_ff, addr1_ff;
   logic                          clamped_in, clamped_ff;
   logic [15:0]                   f_in, f_ff;

   // 37 x 32 product split into a low 32 x 32 part and a high 5 x 32 part
   always_comb begin
      plo_in = 64'(proj.d16[31:0]) * 64'(cfg.inv_spacing);
      phi_in = 37'(proj.d16[36:32]) * 37'(cfg.inv_spacing);
   end

   always_comb begin
      bin      = 38'(phi_ff) + 38'(plo_ff[63:32]);
      frac     = plo_ff[31:0];
      last_ext = 38'(cfg.last);
      addr0_in   = '0;
      addr1_in   = '0;
      clamped_in = 1'b0;
      f_in       = '0;
      if (d_neg_ff) begin
         clamped_in = 1'b1;
      end else if (bin > last_ext || (bin == last_ext && frac != 32'd0)) begin
         addr0_in   = cfg.last;
         addr1_in   = cfg.last;
         clamped_in = 1'b1;
      end else if (bin == last_ext) begin
         addr0_in = cfg.last;
         addr1_in = cfg.last;
      end else begin
         addr0_in = bin[lpti_pkg::ADDR_W-1:0];
         addr1_in = bin[lpti_pkg::ADDR_W-1:0] + 1'b1;
         f_in     = frac[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= proj.valid;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_meta_ff  <= proj.meta;
      d_neg_ff   <= proj.neg;
      plo_ff     <= plo_in;
      phi_ff     <= phi_in;
      e_meta_ff  <= d_meta_ff;
      addr0_ff   <= addr0_in;
      addr1_ff   <= addr1_in;
      clamped_ff <= clamped_in;
      f_ff       <= f_in;
   end

   always_comb begin
      loc.valid    = e_valid_ff;
      loc.meta     = e_meta_ff;
      loc.rd_addr0 = addr0_ff;
      loc.rd_addr1 = addr1_ff;
      loc.clamped  = clamped_ff;
      loc.frac     = f_ff;
   end

endmodule

// ----- src/lpti_table.sv -----
// Sample memory: one write port, two registered read ports, in pipeline order.
module lpti_table (
   input  logic               clock,
   input  logic               reset,
   input  lpti_pkg::loc_type  loc,
   output lpti_pkg::samp_type samp
);

   logic [31:0]                 mem [lpti_pkg::TABLE_DEPTH];
   logic [31:0]                 s0_ff, s1_ff;
   logic                        valid_ff, clamped_ff;
   logic [15:0]                 frac_ff;
   logic                        wr_en;
   logic [lpti_pkg::ADDR_W-1:0] wr_addr;

   always_comb begin
      wr_en   = loc.valid && loc.meta.opcode == lpti_pkg::OP_WRITE
                && 32'(loc.meta.wr_index) < 32'(lpti_pkg::TABLE_DEPTH);
      wr_addr = lpti_pkg::ADDR_W'(loc.meta.wr_index);
   end

   // writes and reads share this stage, so a later item always sees an earlier write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= loc.meta.wr_value;
      end
      s0_ff <= mem[loc.rd_addr0];
      s1_ff <= mem[loc.rd_addr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= loc.valid && loc.meta.opcode == lpti_pkg::OP_INTERP;
      end
   end

   always_ff @(posedge clock) begin
      clamped_ff <= loc.clamped;
      frac_ff    <= loc.frac;
   end

   always_comb begin
      samp.valid   = valid_ff;
      samp.clamped = clamped_ff;
      samp.frac    = frac_ff;
      samp.s0      = s0_ff;
      samp.s1      = s1_ff;
   end

endmodule

// ----- src/lpti_blend.sv -----
// Blend stages: sample difference, weighted product, floor, add and saturate.
module lpti_blend (
   input  logic               clock,
   input  logic               reset,
   input  lpti_pkg::samp_type samp,
   output logic               out_valid,
   output logic [31:0]        out_value,
   output logic               out_clamped
);

   logic                g_valid_ff, h_valid_ff, i_valid_ff;
   logic                g_clamped_ff, h_clamped_ff, i_clamped_ff;
   logic [31:0]         g_s0_ff, h_s0_ff;
   logic [15:0]         g_frac_ff;
   logic signed [32:0]  diff_in, diff_ff;
   logic signed [49:0]  prod_in, prod_ff;
   logic signed [49:0]  shifted;
   logic signed [33:0]  total;
   logic [31:0]         value_in, value_ff;

   always_comb begin
      diff_in = $signed({samp.s1[31], samp.s1}) - $signed({samp.s0[31], samp.s0});
      prod_in = diff_ff * $signed({1'b0, g_frac_ff});
      // arithmetic shift gives floor of the Q16 product
      shifted = prod_ff >>> 16;
      total   = 34'($signed(h_s0_ff)) + 34'(shifted);
      if (total[33] == total[32] && total[32] == total[31]) begin
         value_in = total[31:0];
      end else if (total[33]) begin
         value_in = 32'h8000_0000;
      end else begin
         value_in = 32'h7FFF_FFFF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= samp.valid;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      g_clamped_ff <= samp.clamped;
      g_s0_ff      <= samp.s0;
      g_frac_ff    <= samp.frac;
      diff_ff      <= diff_in;
      h_clamped_ff <= g_clamped_ff;
      h_s0_ff      <= g_s0_ff;
      prod_ff      <= prod_in;
      i_clamped_ff <= h_clamped_ff;
      value_ff     <= value_in;
   end

   assign out_valid   = i_valid_ff;
   assign out_value   = value_ff;
   assign out_clamped = i_clamped_ff;

endmodule

// ----- src/line_projection_table_interp.sv -----
// Top level: register file, projection, location, sample table and blend pipeline.
//
//  channel   ports                                   transfer at
//  request   start, busy, req_*                      rising edge with start high, busy low
//  response  rsp_strobe, rsp_value, rsp_clamped      every edge ending a strobe-high cycle
//  config    csr_write, csr_index, csr_wdata         every edge with csr_write high
//
//  One item enters per cycle; busy stays low. The pipeline is nine register
//  stages (three projection, two locate, table read, three blend): an
//  interpolate item raises the strobe when it reaches the last blend stage
//  and transfers as the strobe cycle ends. Write items update the table
//  in the read stage and give no result. Reset clears all valid bits and
//  loads the register reset values; table contents are kept.
module line_projection_table_interp (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [9:0]  req_entry_index,
   input  logic [31:0] req_entry_value,
   output logic        rsp_strobe,
   output logic [31:0] rsp_value,
   output logic        rsp_clamped,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [31:0]                 start_x_ff, start_y_ff, start_z_ff;
   logic [17:0]                 dir_x_ff, dir_y_ff, dir_z_ff;
   logic [31:0]                 inv_spacing_ff;
   logic [10:0]                 point_count_ff;
   logic [lpti_pkg::ADDR_W-1:0] last;
   logic                        accept;
   lpti_pkg::cfg_type           cfg;
   lpti_pkg::proj_type          proj;
   lpti_pkg::loc_type           loc;
   lpti_pkg::samp_type          samp;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= '0;
         start_y_ff     <= '0;
         start_z_ff     <= '0;
         dir_x_ff       <= 18'd65536;
         dir_y_ff       <= '0;
         dir_z_ff       <= '0;
         inv_spacing_ff <= 32'd65536;
         point_count_ff <= 11'd1024;
      end else if (csr_write) begin
         case (lpti_pkg::csr_index_type'(csr_index))
            lpti_pkg::CSR_AXIS_START_X:    start_x_ff     <= csr_wdata;
            lpti_pkg::CSR_AXIS_START_Y:    start_y_ff     <= csr_wdata;
            lpti_pkg::CSR_AXIS_START_Z:    start_z_ff     <= csr_wdata;
            lpti_pkg::CSR_DIRECTION_X:     dir_x_ff       <= csr_wdata[17:0];
            lpti_pkg::CSR_DIRECTION_Y:     dir_y_ff       <= csr_wdata[17:0];
            lpti_pkg::CSR_DIRECTION_Z:     dir_z_ff       <= csr_wdata[17:0];
            lpti_pkg::CSR_INVERSE_SPACING: inv_spacing_ff <= csr_wdata;
            lpti_pkg::CSR_POINT_COUNT:     point_count_ff <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // point count limited to 2 .. TABLE_DEPTH
   always_comb begin
      if (point_count_ff < 11'd2) begin
         last = lpti_pkg::ADDR_W'(1);
      end else if (32'(point_count_ff) > 32'(lpti_pkg::TABLE_DEPTH)) begin
         last = lpti_pkg::ADDR_W'(lpti_pkg::TABLE_DEPTH - 1);
      end else begin
         last = lpti_pkg::ADDR_W'(point_count_ff - 11'd1);
      end
   end

   always_comb begin
      cfg.start_x     = start_x_ff;
      cfg.start_y     = start_y_ff;
      cfg.start_z     = start_z_ff;
      cfg.dir_x       = dir_x_ff;
      cfg.dir_y       = dir_y_ff;
      cfg.dir_z       = dir_z_ff;
      cfg.inv_spacing = inv_spacing_ff;
      cfg.last        = last;
   end

   lpti_project u_project (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .opcode   (req_opcode),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .pos_z    (req_pos_z),
      .wr_index (req_entry_index),
      .wr_value (req_entry_value),
      .cfg      (cfg),
      .proj     (proj)
   );

   lpti_locate u_locate (
      .clock (clock),
      .reset (reset),
      .proj  (proj),
      .cfg   (cfg),
      .loc   (loc)
   );

   lpti_table u_table (
      .clock (clock),
      .reset (reset),
      .loc   (loc),
      .samp  (samp)
   );

   lpti_blend u_blend (
      .clock       (clock),
      .reset       (reset),
      .samp        (samp),
      .out_valid   (rsp_strobe),
      .out_value   (rsp_value),
      .out_clamped (rsp_clamped)
   );

endmodule
